FILE: src/tfst_pkg.sv
// Package: table geometry, flags, states, actions, controller types.
`timescale 1ns / 1ps
package tfst_pkg;
	localparam int TableSlots = 1024;
	localparam int IdxW = $clog2(TableSlots);
	localparam int OutIdxW = 10;

	localparam int FlFin = 0;
	localparam int FlSyn = 1;
	localparam int FlRst = 2;
	localparam int FlAck = 3;
	localparam int FlEce = 4;

	localparam logic [1:0] MarkSrc = 2'd1;
	localparam logic [1:0] MarkDst = 2'd2;
	localparam logic [3:0] MinSynHdrWords = 4'd5;

	typedef enum logic [2:0] {
		CS_EMPTY = 3'd0, CS_SYN = 3'd1, CS_SYNACK = 3'd2, CS_UP = 3'd3,
		CS_FIN = 3'd4, CS_CLOSED = 3'd5, CS_RESET = 3'd6, CS_UNKNOWN = 3'd7
	} conn_state_t;

	typedef enum logic [2:0] {
		ACT_IGNORE = 3'd0, ACT_OPEN_IN = 3'd1, ACT_OPEN_OUT = 3'd2,
		ACT_UPD_IN = 3'd3, ACT_UPD_OUT = 3'd4, ACT_CLEAR = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC
	} ctl_state_t;

	// One stored slot, one RAM word.
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] ports;
		logic [2:0]  state;
		logic [31:0] last_seen;
		logic [31:0] in_packets;
		logic [31:0] in_volume;
		logic [31:0] out_packets;
		logic [31:0] out_volume;
		logic [31:0] expect_from_dst;
		logic [31:0] expect_from_src;
		logic [1:0]  fin_marks;
	} slot_t;

	localparam int SlotW = $bits(slot_t);

	typedef struct packed {
		logic load;   // capture input item, start read
		logic clr;    // write zero at clear address
		logic exec;   // compute and write back, load result
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
	} dp_sts_t;
endpackage

FILE: src/tfst_if.sv
// Valid/ready stream interface with generic payload.
`timescale 1ns / 1ps
interface tfst_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/tcp_flow_state_tracker.sv
// Top level: TCP flow state tracker.
`timescale 1ns / 1ps
// Hashed TCP connection table. Each header transfer on in_ch selects a slot by
// XOR of addresses and ports, opens, advances, clears or ignores that slot, and
// produces one result transfer on out_ch (slot, action, state, FIN marks).
// A header passes capture, slot RAM read and update/write back in turn, as the
// single-port slot RAM read-modify-write demands; one header is in work at a
// time. A new header is taken only when no result waits on out_ch, or when the
// waiting result leaves in the same cycle.
// After reset a clearing pass writes every slot (TableSlots, 1024) to zero,
// during which in_ch.ready stays low.
module tcp_flow_state_tracker import tfst_pkg::*; (
	input logic clk,
	input logic arst_n,
	tfst_if.sink   in_ch,
	tfst_if.source out_ch
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	tfst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	tfst_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.src_ip(in_ch.data.src_ip), .dst_ip(in_ch.data.dst_ip),
		.src_port(in_ch.data.src_port), .dst_port(in_ch.data.dst_port),
		.seq_num(in_ch.data.seq_num), .ack_num(in_ch.data.ack_num),
		.tcp_flags(in_ch.data.tcp_flags), .ip_hdr_words(in_ch.data.ip_hdr_words),
		.tcp_hdr_words(in_ch.data.tcp_hdr_words),
		.ip_total_len(in_ch.data.ip_total_len), .frame_len(in_ch.data.frame_len),
		.now_time(in_ch.data.now_time),
		.slot_index(out_ch.data.slot_index), .action(out_ch.data.action),
		.conn_state(out_ch.data.conn_state), .fin_seen(out_ch.data.fin_seen)
	);
endmodule

FILE: src/tfst_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tfst_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: src/tfst_ctrl.sv
// Controller: clearing pass, then read / execute per header.
`timescale 1ns / 1ps
module tfst_ctrl import tfst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       take;

	assign out_valid = out_valid_q;
	assign take = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (take) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.load = take;
			end
			ST_READ: ;
			ST_EXEC: cmd.exec = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: src/tfst_dp.sv
// Datapath: hash, slot RAM, table update rules, result register.
`timescale 1ns / 1ps
module tfst_dp import tfst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	output dp_sts_t       sts,
	input  logic [31:0]   src_ip,
	input  logic [31:0]   dst_ip,
	input  logic [15:0]   src_port,
	input  logic [15:0]   dst_port,
	input  logic [31:0]   seq_num,
	input  logic [31:0]   ack_num,
	input  logic [4:0]    tcp_flags,
	input  logic [3:0]    ip_hdr_words,
	input  logic [3:0]    tcp_hdr_words,
	input  logic [15:0]   ip_total_len,
	input  logic [15:0]   frame_len,
	input  logic [31:0]   now_time,
	output logic [OutIdxW-1:0] slot_index,
	output logic [2:0]    action,
	output logic [2:0]    conn_state,
	output logic [1:0]    fin_seen
);
	// captured header
	logic [31:0] sip_q, dip_q, seq_q, ack_q, now_q;
	logic [15:0] sp_q, dp_q, tot_q, flen_q, pay_q;
	logic [4:0]  fl_q;
	logic [3:0]  thw_q;
	logic [IdxW-1:0] idx_q, clr_idx_q;
	logic [IdxW-1:0] idx_new;

	// slot hash is computed from the inputs at load
	logic [31:0] hash_in;
	assign hash_in = src_ip ^ dst_ip ^ {16'd0, src_port} ^ {16'd0, dst_port};
	assign idx_new = hash_in[IdxW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			sts.clr_done <= 1'b0;
		end else if (cmd.clr) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			sts.clr_done <= (clr_idx_q == IdxW'(TableSlots - 2));
		end else begin
			sts.clr_done <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sip_q <= src_ip; dip_q <= dst_ip; sp_q <= src_port; dp_q <= dst_port;
			seq_q <= seq_num; ack_q <= ack_num; fl_q <= tcp_flags;
			thw_q <= tcp_hdr_words; tot_q <= ip_total_len; flen_q <= frame_len;
			now_q <= now_time; idx_q <= idx_new;
			pay_q <= ip_total_len - {10'd0, ip_hdr_words, 2'b00}
				- {10'd0, tcp_hdr_words, 2'b00};
		end
	end

	slot_t rd, wr;
	logic  we;
	logic [IdxW-1:0] addr;
	logic [SlotW-1:0] rdata;

	assign rd = slot_t'(rdata);
	assign we = cmd.clr || cmd.exec;
	assign addr = cmd.clr ? clr_idx_q : (cmd.load ? idx_new : idx_q);

	tfst_ram #(.Width(SlotW), .Depth(TableSlots)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(cmd.clr ? '0 : SlotW'(wr)),
		.rdata(rdata)
	);

	// update rules
	logic fin, syn, rst, ack, ece;
	logic fwd, rev, dir_in;
	logic [31:0] exp_v;
	logic [1:0]  mine, other, marks;
	action_t     act;

	assign fin = fl_q[FlFin];
	assign syn = fl_q[FlSyn];
	assign rst = fl_q[FlRst];
	assign ack = fl_q[FlAck];
	assign ece = fl_q[FlEce];
	assign fwd = (rd.src_ip == sip_q) && (rd.dst_ip == dip_q) && (rd.ports == {sp_q, dp_q});
	assign rev = (rd.src_ip == dip_q) && (rd.dst_ip == sip_q) && (rd.ports == {dp_q, sp_q});
	assign dir_in = fwd;

	always_comb begin
		wr = rd;
		act = ACT_IGNORE;
		exp_v = '0;
		mine = '0; other = '0; marks = '0;
		if (rd.dst_ip == '0) begin
			if (syn) begin
				if (thw_q > MinSynHdrWords) begin
					if (!ack) begin
						wr.src_ip = sip_q; wr.dst_ip = dip_q; wr.ports = {sp_q, dp_q};
						wr.state = CS_SYN;
						wr.in_packets = rd.in_packets + 32'd1;
						wr.in_volume = rd.in_volume + {16'd0, flen_q};
						act = ACT_OPEN_IN;
					end else begin
						wr.src_ip = dip_q; wr.dst_ip = sip_q; wr.ports = {dp_q, sp_q};
						wr.state = CS_SYNACK;
						wr.out_packets = rd.out_packets + 32'd1;
						wr.out_volume = rd.out_volume + {16'd0, flen_q};
						act = ACT_OPEN_OUT;
					end
					wr.last_seen = now_q;
				end
			end else if (!(ece || fin || rst)) begin
				if (sp_q > dp_q) begin
					wr.src_ip = sip_q; wr.dst_ip = dip_q; wr.ports = {sp_q, dp_q};
					wr.in_packets = rd.in_packets + 32'd1;
					wr.in_volume = rd.in_volume + {16'd0, flen_q};
					wr.expect_from_dst = ack_q;
					act = ACT_OPEN_IN;
				end else begin
					wr.src_ip = dip_q; wr.dst_ip = sip_q; wr.ports = {dp_q, sp_q};
					wr.out_packets = rd.out_packets + 32'd1;
					wr.out_volume = rd.out_volume + {16'd0, flen_q};
					wr.expect_from_src = ack_q;
					act = ACT_OPEN_OUT;
				end
				wr.state = CS_UNKNOWN;
				wr.last_seen = now_q;
			end
		end else if (rd.state == CS_CLOSED) begin
			wr = '0;
			act = ACT_CLEAR;
		end else if (fwd || rev) begin
			if (fin) begin
				if (dir_in) wr.expect_from_dst = seq_q + {16'd0, pay_q} + 32'd1;
				else wr.expect_from_src = seq_q + {16'd0, pay_q} + 32'd1;
			end
			// advance sees expected numbers as written by the FIN update
			exp_v = dir_in ? wr.expect_from_src : wr.expect_from_dst;
			mine = dir_in ? MarkSrc : MarkDst;
			other = dir_in ? MarkDst : MarkSrc;
			case (rd.state)
				CS_SYNACK: if (ack) wr.state = CS_UP;
				CS_SYN:    if (syn && ack) wr.state = CS_SYNACK;
				CS_UP:     if (fin) wr.state = CS_FIN;
				CS_FIN: begin
					if (ack && ack_q == exp_v) begin
						marks = rd.fin_marks | mine;
						wr.fin_marks = marks;
						if ((marks & other) != 2'd0) wr.state = CS_CLOSED;
					end
				end
				CS_UNKNOWN: begin
					if (ack) begin
						if (seq_q == exp_v) wr.state = CS_UP;
						else if (dir_in) wr.expect_from_dst = ack_q;
						else wr.expect_from_src = ack_q;
					end
				end
				default: ;
			endcase
			if (rst) wr.state = CS_RESET;
			wr.last_seen = now_q;
			if (dir_in) begin
				wr.in_packets = rd.in_packets + 32'd1;
				wr.in_volume = rd.in_volume + {16'd0, pay_q[12:0], 3'b000};
				act = ACT_UPD_IN;
			end else begin
				wr.out_packets = rd.out_packets + 32'd1;
				wr.out_volume = rd.out_volume + {16'd0, tot_q};
				act = ACT_UPD_OUT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			slot_index <= OutIdxW'(idx_q);
			action <= act;
			conn_state <= wr.state;
			fin_seen <= wr.fin_marks;
		end
	end
endmodule
